// ===== hw/rtl/fpsq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsq_pkg
// Shared types, constants, seed table and product helper for the
// fixed-point square root and magnitude pipeline.
// ----------------------------------------------------------------------------
package fpsq_pkg;

  localparam logic [31:0] ThreeQ30  = 32'hC000_0000;
  localparam logic [30:0] SatMax    = 31'h7FFF_FFFF;
  localparam logic [4:0]  StepSplit = 5'd24;
  localparam logic [4:0]  QReset    = 5'd24;
  localparam int unsigned SeedDepth = 96;

  typedef enum logic [1:0] {
    OP_ISQRT = 2'd0,
    OP_SQRT  = 2'd1,
    OP_MAG   = 2'd2,
    OP_IMAG  = 2'd3
  } op_e;

  typedef struct packed {
    logic       zero;
    logic       sq;
    logic [5:0] base;
  } front_t;

  typedef struct packed {
    logic              zero;
    logic              sq;
    logic              slow;
    logic signed [7:0] expo;
  } side_t;

  localparam logic [15:0] SeedTab [SeedDepth] = '{
    16'h7F02, 16'h7D19, 16'h7B46, 16'h7986, 16'h77D9, 16'h763D, 16'h74B2, 16'h7335,
    16'h71C7, 16'h7066, 16'h6F11, 16'h6DC8, 16'h6C8B, 16'h6B58, 16'h6A2F, 16'h690F,
    16'h67F8, 16'h66EA, 16'h65E4, 16'h64E5, 16'h63EE, 16'h62FE, 16'h6214, 16'h6131,
    16'h6054, 16'h5F7D, 16'h5EAB, 16'h5DDE, 16'h5D17, 16'h5C54, 16'h5B96, 16'h5ADD,
    16'h5A28, 16'h5977, 16'h58CA, 16'h5821, 16'h577C, 16'h56DA, 16'h563C, 16'h55A1,
    16'h5509, 16'h5475, 16'h53E3, 16'h5354, 16'h52C9, 16'h523F, 16'h51B9, 16'h5135,
    16'h50B3, 16'h5034, 16'h4FB7, 16'h4F3D, 16'h4EC4, 16'h4E4E, 16'h4DDA, 16'h4D68,
    16'h4CF7, 16'h4C89, 16'h4C1D, 16'h4BB2, 16'h4B49, 16'h4AE1, 16'h4A7C, 16'h4A18,
    16'h49B5, 16'h4954, 16'h48F4, 16'h4896, 16'h483A, 16'h47DE, 16'h4784, 16'h472C,
    16'h46D4, 16'h467E, 16'h4629, 16'h45D6, 16'h4583, 16'h4532, 16'h44E1, 16'h4492,
    16'h4444, 16'h43F7, 16'h43AA, 16'h435F, 16'h4315, 16'h42CC, 16'h4284, 16'h423C,
    16'h41F6, 16'h41B0, 16'h416B, 16'h4127, 16'h40E4, 16'h40A2, 16'h4060, 16'h4020
  };

  function automatic logic [15:0] seed_lookup(input logic [6:0] idx);
    logic [15:0] val;
    val = '0;
    if (idx < 7'(SeedDepth)) begin
      val = SeedTab[idx];
    end
    return val;
  endfunction

  function automatic logic [31:0] mulhi(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[62:31];
  endfunction

endpackage

// ===== hw/rtl/fpsq_newton.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsq_newton
// One Newton-Raphson step on the inverse square root, cut into three
// registered multiply stages.
// ----------------------------------------------------------------------------
module fpsq_newton (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] norm_i,
  input  logic [31:0] guess_i,
  output logic [31:0] norm_o,
  output logic [31:0] guess_o
);
  import fpsq_pkg::*;

  logic [31:0] t1_q, n1_q, g1_q;
  logic [31:0] t3_q, n2_q, g2_q;
  logic [31:0] g3_q, n3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q <= mulhi(norm_i, guess_i);
      n1_q <= norm_i;
      g1_q <= guess_i;
      t3_q <= ThreeQ30 - mulhi(t1_q, g1_q);
      n2_q <= n1_q;
      g2_q <= g1_q;
      g3_q <= mulhi(g2_q, t3_q);
      n3_q <= n2_q;
    end
  end

  assign norm_o  = n3_q;
  assign guess_o = g3_q;

endmodule

// ===== hw/rtl/fixed_point_sqrt_isqrt_magnitude.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_sqrt_isqrt_magnitude
// Pipelined square root, inverse square root, magnitude and inverse
// magnitude of signed fixed-point operands.
// ----------------------------------------------------------------------------
// The block takes one word per clock unless the output stalls and returns the
// results in order. The depth is set by the nine multiply stages of the three
// Newton-Raphson steps, plus squaring, the sum of squares, two normalization
// stages, the seed lookup, the final product and the output scaling. A stall on
// the output holds the whole pipeline. Write q_format only while the pipeline
// is empty.
module fixed_point_sqrt_isqrt_magnitude (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic signed [31:0] x_value_i,
  input  logic signed [31:0] y_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [30:0] result_o
);
  import fpsq_pkg::*;

  localparam int unsigned NtLat = 9;

  logic        en;
  logic [4:0]  q_q;

  logic              s1_vld_q;
  logic [1:0]        s1_op_q;
  logic signed [31:0] s1_x_q;
  logic signed [63:0] s1_px_q, s1_py_q;

  logic        s2_vld_q;
  logic [63:0] s2_v_q, s2_v_d;
  front_t      s2_f_q, s2_f_d;
  logic [63:0] sum;
  logic [31:0] xs;

  logic        s3_vld_q;
  logic [63:0] s3_v_q, s3_v_d;
  logic [5:0]  s3_sh_q, s3_sh_d;
  front_t      s3_f_q;

  logic        s4_vld_q;
  logic [31:0] s4_norm_q;
  side_t       s4_sb_q, s4_sb_d;
  logic [63:0] v4;
  logic [5:0]  sh4;
  logic signed [7:0] dd, qm;

  logic        s5_vld_q;
  logic [31:0] s5_norm_q, s5_guess_q;
  side_t       s5_sb_q;

  logic [31:0] nt_norm [3];
  logic [31:0] nt_guess [3];
  logic        nt_vld_q [NtLat];
  side_t       nt_sb_q [NtLat];
  logic [31:0] g2d_q [3];
  logic [31:0] gsel;

  logic        s15_vld_q;
  logic [31:0] s15_res_q;
  side_t       s15_sb_q;

  logic        out_vld_q;
  logic [30:0] out_res_q, out_res_d;
  logic [7:0]  ne;
  logic [31:0] rs;
  logic [32:0] r1;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= QReset;
    end else if (cfg_we_i) begin
      q_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s15_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < NtLat; i++) begin
        nt_vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      s1_vld_q    <= in_valid_i;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      s4_vld_q    <= s3_vld_q;
      s5_vld_q    <= s4_vld_q;
      nt_vld_q[0] <= s5_vld_q;
      for (int i = 1; i < NtLat; i++) begin
        nt_vld_q[i] <= nt_vld_q[i-1];
      end
      s15_vld_q <= nt_vld_q[NtLat-1];
      out_vld_q <= s15_vld_q;
    end
  end

  always_comb begin
    sum  = s1_px_q + s1_py_q;
    xs   = q_q[0] ? {s1_x_q[30:0], 1'b0} : s1_x_q;
    if (s1_op_q[1]) begin
      s2_v_d        = sum;
      s2_f_d.zero   = (sum == 64'd0);
      s2_f_d.base   = 6'd32 - {1'b0, q_q};
    end else begin
      s2_v_d        = {xs, 32'd0};
      s2_f_d.zero   = s1_x_q[31] || (s1_x_q == 32'sd0);
      s2_f_d.base   = (6'd32 - {1'b0, q_q}) >> 1;
    end
    s2_f_d.sq = (s1_op_q == OP_SQRT) || (s1_op_q == OP_MAG);
  end

  always_comb begin
    s3_v_d  = s2_v_q;
    s3_sh_d = '0;
    if (s3_v_d[63:32] == '0) begin
      s3_v_d  = {s3_v_d[31:0], 32'd0};
      s3_sh_d = s3_sh_d + 6'd32;
    end
    if (s3_v_d[63:48] == '0) begin
      s3_v_d  = {s3_v_d[47:0], 16'd0};
      s3_sh_d = s3_sh_d + 6'd16;
    end
    if (s3_v_d[63:56] == '0) begin
      s3_v_d  = {s3_v_d[55:0], 8'd0};
      s3_sh_d = s3_sh_d + 6'd8;
    end
  end

  always_comb begin
    v4  = s3_v_q;
    sh4 = s3_sh_q;
    if (v4[63:60] == '0) begin
      v4  = {v4[59:0], 4'd0};
      sh4 = sh4 + 6'd4;
    end
    if (v4[63:62] == '0) begin
      v4  = {v4[61:0], 2'd0};
      sh4 = sh4 + 6'd2;
    end
    dd = $signed({2'b00, s3_f_q.base}) - $signed({3'b000, sh4[5:1]});
    qm = $signed(8'(5'd31 - q_q));
    s4_sb_d.zero = s3_f_q.zero;
    s4_sb_d.sq   = s3_f_q.sq;
    s4_sb_d.slow = (q_q >= StepSplit);
    s4_sb_d.expo = s3_f_q.sq ? (dd - qm) : (8'sd1 - dd - qm);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (in_valid_i) begin
        s1_op_q <= operation_i;
        s1_x_q  <= x_value_i;
        s1_px_q <= x_value_i * x_value_i;
        s1_py_q <= y_value_i * y_value_i;
      end
      s2_v_q     <= s2_v_d;
      s2_f_q     <= s2_f_d;
      s3_v_q     <= s3_v_d;
      s3_sh_q    <= s3_sh_d;
      s3_f_q     <= s2_f_q;
      s4_norm_q  <= v4[63:32];
      s4_sb_q    <= s4_sb_d;
      s5_norm_q  <= s4_norm_q;
      s5_guess_q <= {seed_lookup(7'(s4_norm_q[31:25] - 7'd32)), 16'd0};
      s5_sb_q    <= s4_sb_q;
      nt_sb_q[0] <= s5_sb_q;
      for (int i = 1; i < NtLat; i++) begin
        nt_sb_q[i] <= nt_sb_q[i-1];
      end
      g2d_q[0] <= nt_guess[1];
      g2d_q[1] <= g2d_q[0];
      g2d_q[2] <= g2d_q[1];
      s15_res_q <= nt_sb_q[NtLat-1].sq ? mulhi(gsel, nt_norm[2]) : gsel;
      s15_sb_q  <= nt_sb_q[NtLat-1];
      out_res_q <= out_res_d;
    end
  end

  fpsq_newton u_step0 (
    .clk_i   (clk_i),
    .en_i    (en),
    .norm_i  (s5_norm_q),
    .guess_i (s5_guess_q),
    .norm_o  (nt_norm[0]),
    .guess_o (nt_guess[0])
  );

  fpsq_newton u_step1 (
    .clk_i   (clk_i),
    .en_i    (en),
    .norm_i  (nt_norm[0]),
    .guess_i (nt_guess[0]),
    .norm_o  (nt_norm[1]),
    .guess_o (nt_guess[1])
  );

  fpsq_newton u_step2 (
    .clk_i   (clk_i),
    .en_i    (en),
    .norm_i  (nt_norm[1]),
    .guess_i (nt_guess[1]),
    .norm_o  (nt_norm[2]),
    .guess_o (nt_guess[2])
  );

  assign gsel = nt_sb_q[NtLat-1].slow ? nt_guess[2] : g2d_q[2];

  always_comb begin
    ne = 8'(-s15_sb_q.expo - 8'sd1);
    rs = s15_res_q >> ne[4:0];
    r1 = {1'b0, rs} + 33'd1;
    if (s15_sb_q.zero) begin
      out_res_d = '0;
    end else if (s15_sb_q.expo > 8'sd0) begin
      out_res_d = SatMax;
    end else if (s15_sb_q.expo <= -8'sd32) begin
      out_res_d = '0;
    end else if (s15_sb_q.expo < 8'sd0) begin
      out_res_d = (r1[32:1] > {1'b0, SatMax}) ? SatMax : r1[31:1];
    end else begin
      out_res_d = (s15_res_q > {1'b0, SatMax}) ? SatMax : s15_res_q[30:0];
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = out_res_q;

`ifndef SYNTHESIS
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_vld_q)
    else $error("accepted word did not enter the pipeline");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(s15_vld_q) && $stable(s5_vld_q))
    else $error("pipeline moved during an output stall");

  a_normalized : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_vld_q && !s4_sb_q.zero |-> s4_norm_q[31:30] != 2'b00)
    else $error("operand not normalized");
`endif

endmodule
